// ===== src/srfd_pkg.sv =====
package srfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int AXIS_W      = 3;
    localparam int AXES        = 5;
    localparam int COUNT_W     = 4;
    localparam int MAX_CONTENT = 10;
    localparam int QDEPTH      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_PAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
    localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_BRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_K      = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
    localparam logic [BYTE_W-1:0] CH_X      = 8'h58;
    localparam logic [BYTE_W-1:0] CH_Y      = 8'h59;
    localparam logic [BYTE_W-1:0] CH_Z      = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_W      = 8'h57;
    localparam logic [BYTE_W-1:0] CH_O      = 8'h4F;
    localparam logic [BYTE_W-1:0] RESET_OFS = 8'h10;

    localparam logic [KIND_W-1:0] KIND_COMMTEST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POSITION = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MOVING   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LIGHT    = 3'd6;

    localparam logic [AXIS_W-1:0] AXIS_X = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_W_CODE = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_O = 3'd4;

    typedef struct packed {
        logic              ok;
        logic [AXIS_W-1:0] code;
    } axis_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic axis_t axis_of(input logic [BYTE_W-1:0] letter);
        axis_t a;
        a.ok = 1'b1;
        case (letter)
            CH_X:    a.code = AXIS_X;
            CH_Y:    a.code = AXIS_Y;
            CH_Z:    a.code = AXIS_Z;
            CH_W:    a.code = AXIS_W_CODE;
            CH_O:    a.code = AXIS_O;
            default:
            begin
                a.ok   = 1'b0;
                a.code = AXIS_X;
            end
        endcase
        return a;
    endfunction

endpackage

// ===== src/srfd_if.sv =====
interface srfd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [srfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfd_evt_if;
    logic                        valid;
    logic                        ready;
    logic [srfd_pkg::KIND_W-1:0] event_kind;

    modport source (output valid, output event_kind, input ready);
    modport sink (input valid, input event_kind, output ready);
endinterface

// ===== src/stage_reply_frame_decoder_core.sv =====
// Channel | Direction | Payload           | Accepted when
// rx      | in        | rx_byte [7:0]     | rx.valid && rx.ready
// evt     | out       | event_kind [2:0]  | evt.valid && evt.ready
// cfg     | in        | cfg_wdata [4:0]   | cfg_we
//
// One byte is accepted every cycle while the reply queue has room.
// A closing '$' yields its event through the queue and then the output register.
// The queue only fills when the event consumer stalls; then rx.ready drops.
// Reset clears the frame state, the queue, the output valid flag and the axis enables.
module stage_reply_frame_decoder_core #(
    parameter int MAX_CONTENT = srfd_pkg::MAX_CONTENT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    srfd_rx_if.sink                   rx,
    srfd_evt_if.source                evt,
    input  logic                      cfg_we,
    input  logic [srfd_pkg::AXES-1:0] cfg_wdata
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           q_valid;
    srfd_pkg::cmd_t push_cmd;
    srfd_pkg::cmd_t q_cmd;

    assign rx.ready = !full;
    assign accept   = rx.valid && !full;

    srfd_front #(
        .MAX_CONTENT (MAX_CONTENT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx.rx_byte),
        .push     (push),
        .push_cmd (push_cmd)
    );

    srfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    srfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .out_kind  (evt.event_kind)
    );

endmodule

// ===== src/srfd_front.sv =====
module srfd_front #(
    parameter int MAX_CONTENT = srfd_pkg::MAX_CONTENT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [srfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                        push,
    output srfd_pkg::cmd_t              push_cmd
);

    localparam int IDX_W = $clog2(MAX_CONTENT);
    localparam int CMP_W = srfd_pkg::COUNT_W + 1;

    logic                              in_frame_reg;
    logic                              in_frame_next;
    logic [srfd_pkg::COUNT_W-1:0]      count_reg;
    logic [srfd_pkg::COUNT_W-1:0]      count_next;
    logic [srfd_pkg::BYTE_W-1:0]       content_reg [MAX_CONTENT];

    logic                              is_open;
    logic                              is_close;
    logic                              store;
    logic                              cand_ok;
    logic                              len_ok;
    logic [srfd_pkg::BYTE_W-1:0]       b0;
    logic [srfd_pkg::BYTE_W-1:0]       b1;
    logic [srfd_pkg::BYTE_W-1:0]       b2;
    logic [srfd_pkg::BYTE_W-1:0]       reset_letter;
    logic                              hex_2_3;
    logic                              hex_4_5;
    logic                              hex_6_9;
    srfd_pkg::axis_t                   axis_b1;
    srfd_pkg::axis_t                   axis_rst;

    assign is_open  = (rx_byte == srfd_pkg::CH_OPEN);
    assign is_close = (rx_byte == srfd_pkg::CH_CLOSE);
    assign store    = accept && in_frame_reg && !is_open && !is_close &&
                      (CMP_W'(count_reg) < CMP_W'(MAX_CONTENT));

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (is_open)
            begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end
            else if (in_frame_reg && is_close)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end
            else if (in_frame_reg && count_reg != srfd_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            content_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign b0 = content_reg[0];
    assign b1 = (count_reg >= 4'd2) ? content_reg[1] : '0;
    assign b2 = content_reg[2];
    assign reset_letter = (b1 == srfd_pkg::CH_K) ? srfd_pkg::CH_W
                                                 : b1 + srfd_pkg::RESET_OFS;
    assign hex_2_3 = srfd_pkg::is_hex(content_reg[2]) && srfd_pkg::is_hex(content_reg[3]);
    assign hex_4_5 = srfd_pkg::is_hex(content_reg[4]) && srfd_pkg::is_hex(content_reg[5]);
    assign hex_6_9 = srfd_pkg::is_hex(content_reg[6]) && srfd_pkg::is_hex(content_reg[7]) &&
                     srfd_pkg::is_hex(content_reg[8]) && srfd_pkg::is_hex(content_reg[9]);
    assign axis_b1  = srfd_pkg::axis_of(b1);
    assign axis_rst = srfd_pkg::axis_of(reset_letter);
    assign len_ok   = (count_reg != '0) && (CMP_W'(count_reg) <= CMP_W'(MAX_CONTENT));

    always_comb
    begin
        cand_ok       = 1'b0;
        push_cmd.kind = srfd_pkg::KIND_COMMTEST;
        push_cmd.axis = srfd_pkg::AXIS_X;
        case (b0)
            srfd_pkg::CH_EQUAL:
            begin
                cand_ok = 1'b1;
            end
            srfd_pkg::CH_CARET,
            srfd_pkg::CH_PAREN:
            begin
                cand_ok       = (count_reg == 4'd10) && hex_2_3 && hex_4_5 && hex_6_9 &&
                                axis_b1.ok;
                push_cmd.kind = (b0 == srfd_pkg::CH_CARET) ? srfd_pkg::KIND_POSITION
                                                           : srfd_pkg::KIND_MOVED;
                push_cmd.axis = axis_b1.code;
            end
            srfd_pkg::CH_BANG:
            begin
                cand_ok       = (count_reg == 4'd3) && (b2 == srfd_pkg::CH_W) && axis_b1.ok;
                push_cmd.kind = srfd_pkg::KIND_ERROR;
                push_cmd.axis = axis_b1.code;
            end
            srfd_pkg::CH_AT:
            begin
                cand_ok       = (count_reg == 4'd2) && axis_rst.ok;
                push_cmd.kind = srfd_pkg::KIND_RESET;
                push_cmd.axis = axis_rst.code;
            end
            srfd_pkg::CH_BAR:
            begin
                cand_ok       = (count_reg == 4'd3) && axis_b1.ok &&
                                (b2 == srfd_pkg::CH_ZERO || b2 == srfd_pkg::CH_ONE);
                push_cmd.kind = srfd_pkg::KIND_MOVING;
                push_cmd.axis = axis_b1.code;
            end
            srfd_pkg::CH_BRACK:
            begin
                cand_ok       = (b1 == srfd_pkg::CH_L) &&
                                (((count_reg == 4'd4) && hex_2_3) ||
                                 ((count_reg == 4'd6) && hex_2_3 && hex_4_5));
                push_cmd.kind = srfd_pkg::KIND_LIGHT;
                push_cmd.axis = srfd_pkg::AXIS_O;
            end
            default:
            begin
                cand_ok = 1'b0;
            end
        endcase
    end

    assign push = accept && in_frame_reg && is_close && len_ok && cand_ok;

    a_open_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_open |=> in_frame_reg && count_reg == '0)
        else $error("frame open did not restart the frame");

    a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_frame_reg && is_close |=> !in_frame_reg)
        else $error("frame close left the frame open");

endmodule

// ===== src/srfd_queue.sv =====
module srfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srfd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           q_valid,
    output srfd_pkg::cmd_t q_cmd
);

    localparam int PTR_W = (srfd_pkg::QDEPTH > 1) ? $clog2(srfd_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(srfd_pkg::QDEPTH + 1);

    srfd_pkg::cmd_t   mem [srfd_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(srfd_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(srfd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !q_valid))
        else $error("queue pushed while full or popped while empty");

endmodule

// ===== src/srfd_back.sv =====
module srfd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [srfd_pkg::AXES-1:0]   cfg_wdata,
    input  logic                        q_valid,
    input  srfd_pkg::cmd_t              q_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [srfd_pkg::KIND_W-1:0] out_kind
);

    logic [srfd_pkg::AXES-1:0]   enabled_reg;
    logic                        valid_reg;
    logic                        valid_next;
    logic [srfd_pkg::KIND_W-1:0] kind_reg;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = enabled_reg[q_cmd.axis];
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= q_cmd.kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> kind_reg <= srfd_pkg::KIND_LIGHT)
        else $error("event kind out of range");

endmodule

// ===== tb/tb_stage_reply_frame_decoder_core.sv =====
module tb_stage_reply_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srfd_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 10;
    localparam int POS_LEN     = 10;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [AXES-1:0] cfg_wdata;

    srfd_rx_if  rx_ch ();
    srfd_evt_if evt_ch ();

    stage_reply_frame_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [BYTE_W-1:0] byte_q [$];
    logic [KIND_W-1:0] reply_q [$];

    logic [AXES-1:0]   axis_en;
    logic              in_frame;
    int                frame_len;
    logic [BYTE_W-1:0] frame_buf [MAX_CONTENT];

    logic rx_taken;
    logic holding;
    logic pressure_go;
    int   send_idle;
    int   recv_stall;
    int   fail_cnt;
    int   cycle_cnt;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic is_hex_digit(input logic [BYTE_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic digits_hex(input int from, input int upto);
        int i;
        for (i = from; i < upto; i++)
        begin
            if (i >= MAX_CONTENT || !is_hex_digit(frame_buf[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic axis_on(input logic [BYTE_W-1:0] letter);
        case (letter)
            CH_X:    return axis_en[0];
            CH_Y:    return axis_en[1];
            CH_Z:    return axis_en[2];
            CH_W:    return axis_en[3];
            CH_O:    return axis_en[4];
            default: return 1'b0;
        endcase
    endfunction

    // Decodes the content of a closed frame; returns whether an event is given.
    function automatic logic reply_event(input int len, output logic [KIND_W-1:0] kind);
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] letter;
        kind = KIND_COMMTEST;
        if (len == 0)
            return 1'b0;
        b1 = (len >= 2) ? frame_buf[1] : 8'h00;
        case (frame_buf[0])
            CH_EQUAL:
            begin
                kind = KIND_COMMTEST;
                return axis_on(CH_X);
            end
            CH_CARET, CH_PAREN:
            begin
                kind = (frame_buf[0] == CH_CARET) ? KIND_POSITION : KIND_MOVED;
                return len == POS_LEN && digits_hex(2, POS_LEN) && axis_on(b1);
            end
            CH_BANG:
            begin
                kind = KIND_ERROR;
                return len == 3 && frame_buf[2] == CH_W && axis_on(b1);
            end
            CH_AT:
            begin
                kind = KIND_RESET;
                letter = (b1 == CH_K) ? CH_W : b1 + RESET_OFS;
                return len == 2 && axis_on(letter);
            end
            CH_BAR:
            begin
                kind = KIND_MOVING;
                return len == 3 && (frame_buf[2] == CH_ZERO || frame_buf[2] == CH_ONE) &&
                       axis_on(b1);
            end
            CH_BRACK:
            begin
                kind = KIND_LIGHT;
                return (len == 4 || len == 6) && b1 == CH_L && digits_hex(2, len) &&
                       axis_on(CH_O);
            end
            default: return 1'b0;
        endcase
    endfunction

    // Sender side of the request channel.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
        end
        else if (!rx_ch.valid || rx_taken)
        begin
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= byte_q.pop_front();
            end
            else
            begin
                rx_ch.valid   <= 1'b0;
                rx_ch.rx_byte <= 8'($urandom_range(255));
            end
        end
    end

    always @(negedge clk)
    begin
        evt_ch.ready <= !holding && ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin : monitor
        logic [BYTE_W-1:0] b;
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] want;
        rx_taken <= rx_ch.valid && rx_ch.ready;
        if (rst_n && cfg_we)
            axis_en <= cfg_wdata;
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            b = rx_ch.rx_byte;
            if (b == CH_OPEN)
            begin
                in_frame  = 1'b1;
                frame_len = 0;
            end
            else if (in_frame)
            begin
                if (b == CH_CLOSE)
                begin
                    in_frame = 1'b0;
                    if (frame_len <= MAX_CONTENT && reply_event(frame_len, kind))
                        reply_q.push_back(kind);
                    frame_len = 0;
                end
                else
                begin
                    if (frame_len < MAX_CONTENT)
                        frame_buf[frame_len] = b;
                    if (frame_len < int'(COUNT_MAX))
                        frame_len++;
                end
            end
        end
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            if (reply_q.size() == 0)
            begin
                $error("event_kind: no event expected, got %0d", evt_ch.event_kind);
                fail_cnt++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (evt_ch.event_kind !== want)
                begin
                    $error("event_kind: expected %0d, got %0d", want, evt_ch.event_kind);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic write_axes(input logic [AXES-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || rx_ch.valid || reply_q.size() != 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_OPEN || b == CH_CLOSE)
            b = b ^ 8'h40;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char();
        int n;
        n = $urandom_range(21);
        if (n < 10)
            return 8'(int'("0") + n);
        else if (n < 16)
            return 8'(int'("A") + n - 10);
        else
            return 8'(int'("a") + n - 16);
    endfunction

    function automatic logic [BYTE_W-1:0] axis_letter();
        case ($urandom_range(7))
            0:       return CH_X;
            1:       return CH_Y;
            2:       return CH_Z;
            3:       return CH_W;
            4:       return CH_O;
            5:       return CH_X;
            6:       return CH_O;
            default: return body_byte();
        endcase
    endfunction

    // Builds one reply frame with random content, mostly well formed.
    task automatic add_frame(inout int sent);
        logic [BYTE_W-1:0] body [$];
        int                n;
        int                i;
        case ($urandom_range(7))
            0:
            begin
                body.push_back(CH_EQUAL);
                n = $urandom_range(4);
                for (i = 0; i < n; i++)
                    body.push_back(body_byte());
            end
            1, 2:
            begin
                body.push_back($urandom_range(1) ? CH_CARET : CH_PAREN);
                body.push_back(axis_letter());
                for (i = 0; i < 8; i++)
                    body.push_back(hex_char());
            end
            3:
            begin
                body.push_back(CH_BANG);
                body.push_back(axis_letter());
                body.push_back($urandom_range(5) ? CH_W : body_byte());
            end
            4:
            begin
                body.push_back(CH_AT);
                case ($urandom_range(6))
                    0:       body.push_back("H");
                    1:       body.push_back("I");
                    2:       body.push_back("J");
                    3:       body.push_back(CH_K);
                    4:       body.push_back("G");
                    5:       body.push_back("?");
                    default: body.push_back(body_byte());
                endcase
            end
            5:
            begin
                body.push_back(CH_BAR);
                body.push_back(axis_letter());
                case ($urandom_range(4))
                    0, 1:    body.push_back(CH_ZERO);
                    2, 3:    body.push_back(CH_ONE);
                    default: body.push_back(body_byte());
                endcase
            end
            6:
            begin
                body.push_back(CH_BRACK);
                body.push_back($urandom_range(5) ? CH_L : body_byte());
                n = $urandom_range(1) ? 2 : 4;
                for (i = 0; i < n; i++)
                    body.push_back(hex_char());
            end
            default:
            begin
                n = $urandom_range(14);
                for (i = 0; i < n; i++)
                    body.push_back(body_byte());
            end
        endcase
        if (body.size() > 0)
        begin
            case ($urandom_range(15))
                0: body[$urandom_range(body.size() - 1)] = body_byte();
                1: void'(body.pop_back());
                2: body.push_back(body_byte());
                3: body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
                default: ;
            endcase
        end
        if ($urandom_range(5) == 0)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                byte_q.push_back(8'($urandom_range(255)));
        end
        byte_q.push_back(CH_OPEN);
        foreach (body[j])
            byte_q.push_back(body[j]);
        if ($urandom_range(19) != 0)
            byte_q.push_back(CH_CLOSE);
        sent += body.size() + 2;
    endtask

    initial
    begin : stimulus
        logic [AXES-1:0] en_list [8];
        int              sent;
        int              target;
        int              p;
        int              i;
        en_list = '{5'h1F, 5'h00, 5'h15, 5'h0A, 5'h10, 5'h01, 5'h1F, 5'h00};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        evt_ch.ready  = 1'b0;
        rx_taken      = 1'b0;
        holding       = 1'b0;
        pressure_go   = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        fail_cnt      = 0;
        axis_en       = '0;
        in_frame      = 1'b0;
        frame_len     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_axes(5'h1F);
        @(posedge clk);
        push_text("*=$*^X0123ABCD$*(Yabcdef98$*!ZW$*|W0$*|O1$*|X2$");
        push_text("*@H$*@I$*@J$*@K$*@G$*@?$*[L9F$*[LA0b1$");
        push_text("*$$*#Q$*^X0123ABCG$*!QW$*=0123456789ABCD$**!XW$");
        byte_q.push_back(8'hFF);
        byte_q.push_back(CH_OPEN);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(CH_CLOSE);
        wait_idle();

        for (p = 0; p < 8; p++)
        begin
            write_axes((p == 7) ? AXES'($urandom_range(31)) : en_list[p]);
            @(posedge clk);
            case (p % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 50;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 50;
                end
                default:
                begin
                    send_idle  = 10;
                    recv_stall = 10;
                end
            endcase
            sent   = 0;
            target = (en_list[p] == 5'h00 && p != 7) ? 40 : 80;
            while (sent < target)
                add_frame(sent);
            wait_idle();
        end

        // The consumer holds off while requests keep coming, so the block backs up.
        write_axes(5'h1F);
        @(posedge clk);
        send_idle   = 0;
        recv_stall  = 0;
        pressure_go = 1'b1;
        for (i = 0; i < 40; i++)
            push_text("*=$");
        sent = 0;
        while (sent < 60)
            add_frame(sent);
        wait_idle();

        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
